FILE: sv/csa_pkg.sv
// Shared types and constants for the chi-square accumulator core.
package csa_pkg;

  localparam int POS_W    = 16;
  localparam int VAL_W    = 32;
  localparam int OERR_W   = 31;
  localparam int SUM_W    = 48;
  localparam int ESUM_W   = 64;
  localparam int DEN_W    = 2 * OERR_W;
  localparam int ROOT_W   = ESUM_W / 2;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 2 * SUM_W;
  localparam int OUT_USER_W = 2;

  // Quotient bits produced per point: chi term and error-term quotient.
  localparam int CHI_Q_W  = SUM_W;
  localparam int T_Q_W    = 32;
  localparam int CNT_W    = 6;

  localparam logic [POS_W-1:0] THRESHOLD_RESET = 16'd1536;
  localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};
  localparam logic [ESUM_W-1:0] ESUM_MAX       = {ESUM_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DEN,
    ST_MUL_A2,
    ST_MUL_AM,
    ST_DIV_INIT,
    ST_DIV,
    ST_MUL_T,
    ST_ACC,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_OUT
  } csa_state_t;

endpackage

FILE: sv/chi_square_accumulator_core.sv
// Chi-square goodness-of-fit accumulator with bit-serial divide and square root.
// Per point: a point below the threshold or with zero error is absorbed in idle; any other point
//   runs through transfer, 3 multiply steps, divide setup, 48-step divide, square, sum.
// Result: once a last point's work ends, setup, a 32-step square root of the error sum and a
//   load follow; the result is held in an output register until taken.
// Reset (rst, synchronous): sums and flags clear, threshold returns to 6.0 (Q8.8).
module chi_square_accumulator_core (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: position threshold, unsigned Q8.8
  input  logic                            cfg_wr_en,
  input  logic [csa_pkg::POS_W-1:0]       cfg_wr_data,
  // Points in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // position[15:0], observed[47:16], observed_error[78:48], model_value[110:79],
  // model_error[142:111], zero[143]
  input  logic [csa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,   // last_point
  // Results out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // chi_square[47:0], chi_square_error[95:48]
  output logic [csa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // saturated[0], zero_error_seen[1]
  output logic [csa_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  csa_pkg::csa_state_t state, state_next;

  // Input field unpack
  logic [csa_pkg::POS_W-1:0]  in_pos;
  logic [csa_pkg::VAL_W-1:0]  in_obs;
  logic [csa_pkg::OERR_W-1:0] in_oerr;
  logic [csa_pkg::VAL_W-1:0]  in_mod;
  logic [csa_pkg::VAL_W-1:0]  in_merr;

  assign in_pos  = s_axis_tdata[15:0];
  assign in_obs  = s_axis_tdata[47:16];
  assign in_oerr = s_axis_tdata[78:48];
  assign in_mod  = s_axis_tdata[110:79];
  assign in_merr = s_axis_tdata[142:111];

  // |obs - model| fits 32 bits; |model_error| fits 32 bits unsigned.
  logic [csa_pkg::VAL_W:0]   in_diff;
  logic [csa_pkg::VAL_W-1:0] in_a_abs;
  logic [csa_pkg::VAL_W-1:0] in_m_abs;

  assign in_diff  = {in_obs[csa_pkg::VAL_W-1], in_obs} - {in_mod[csa_pkg::VAL_W-1], in_mod};
  assign in_a_abs = in_diff[csa_pkg::VAL_W] ? csa_pkg::VAL_W'(~in_diff + 1'b1)
                                            : in_diff[csa_pkg::VAL_W-1:0];
  assign in_m_abs = in_merr[csa_pkg::VAL_W-1] ? (~in_merr + 1'b1) : in_merr;

  // Accumulator state
  logic [csa_pkg::POS_W-1:0]  threshold;
  logic [csa_pkg::SUM_W-1:0]  chi_sum;
  logic [csa_pkg::ESUM_W-1:0] error_sum;
  logic                       saturate_flag;
  logic                       zero_flag;

  logic in_xfer;
  logic in_skip;
  logic in_zero;
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_skip = in_pos < threshold;
  assign in_zero = (in_oerr == '0);

  // Per-point operands
  logic [csa_pkg::VAL_W-1:0]  a_abs;
  logic [csa_pkg::VAL_W-1:0]  m_abs;
  logic [csa_pkg::OERR_W-1:0] oerr;
  logic                       last;
  logic [csa_pkg::DEN_W-1:0]  den;
  logic [2*csa_pkg::VAL_W-1:0] a2;
  logic [2*csa_pkg::VAL_W-2:0] am;    // a * m, so p = 2*a*m = am << 1

  // Serial dividers: the dividend shift register takes quotient bits in at the bottom.
  logic [csa_pkg::DEN_W-1:0]   crem;
  logic [csa_pkg::CHI_Q_W-1:0] cn;
  logic                        csat;
  logic [csa_pkg::DEN_W-1:0]   trem;
  logic [csa_pkg::T_Q_W-1:0]   tn;
  logic                        tsat;
  logic [csa_pkg::CNT_W-1:0]   cnt;
  logic [csa_pkg::ESUM_W-1:0]  eterm;

  // Serial square root
  logic [csa_pkg::ESUM_W-1:0]  sx;
  logic [csa_pkg::ROOT_W:0]    srem;
  logic [csa_pkg::ROOT_W-1:0]  root;

  // Shared 32x32 multiplier, operands picked by state
  logic [csa_pkg::VAL_W-1:0]   mul_x, mul_y;
  logic [2*csa_pkg::VAL_W-1:0] mul_p;

  always_comb begin
    case (state)
      csa_pkg::ST_MUL_DEN: begin
        mul_x = {1'b0, oerr};
        mul_y = {1'b0, oerr};
      end
      csa_pkg::ST_MUL_A2: begin
        mul_x = a_abs;
        mul_y = a_abs;
      end
      csa_pkg::ST_MUL_AM: begin
        mul_x = a_abs;
        mul_y = m_abs;
      end
      default: begin
        mul_x = tn;
        mul_y = tn;
      end
    endcase
  end

  assign mul_p = (2*csa_pkg::VAL_W)'(mul_x) * (2*csa_pkg::VAL_W)'(mul_y);

  // One restoring-division step for each quotient
  logic [csa_pkg::DEN_W:0] c_sh, c_dif, t_sh, t_dif;
  logic                    c_ge, t_ge;

  assign c_sh  = {crem, cn[csa_pkg::CHI_Q_W-1]};
  assign c_dif = c_sh - {1'b0, den};
  assign c_ge  = (c_sh >= {1'b0, den});
  assign t_sh  = {trem, tn[csa_pkg::T_Q_W-1]};
  assign t_dif = t_sh - {1'b0, den};
  assign t_ge  = (t_sh >= {1'b0, den});

  // One square-root step: bring down two radicand bits, try (root << 2) | 1.
  logic [csa_pkg::ROOT_W+2:0] s_sh, s_trial, s_dif;
  logic                       s_ge;

  assign s_sh    = {srem, sx[csa_pkg::ESUM_W-1 -: 2]};
  assign s_trial = {1'b0, root, 2'b01};
  assign s_dif   = s_sh - s_trial;
  assign s_ge    = (s_sh >= s_trial);

  // Saturation checks on the first remainder: a quotient too wide to hold.
  logic [csa_pkg::DEN_W-1:0] c_rem0, t_rem0;
  assign c_rem0 = csa_pkg::DEN_W'(a2[2*csa_pkg::VAL_W-1:csa_pkg::VAL_W]);
  assign t_rem0 = csa_pkg::DEN_W'(am[2*csa_pkg::VAL_W-2:15]);

  // Term and sum arithmetic
  logic [csa_pkg::SUM_W-1:0]  chi_term;
  logic [csa_pkg::SUM_W:0]    chi_add;
  logic [csa_pkg::ESUM_W:0]   err_add;
  assign chi_term = csat ? csa_pkg::SUM_MAX : cn;
  assign chi_add  = {1'b0, chi_sum} + {1'b0, chi_term};
  assign err_add  = {1'b0, error_sum} + {1'b0, eterm};

  logic out_load;
  logic div_done;
  logic root_done;
  assign div_done  = (cnt == csa_pkg::CNT_W'(csa_pkg::CHI_Q_W - 1));
  assign root_done = (cnt == csa_pkg::CNT_W'(csa_pkg::ROOT_W - 1));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state)
      csa_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (!in_skip && !in_zero) begin
            state_next = csa_pkg::ST_MUL_DEN;
          end else if (s_axis_tlast) begin
            state_next = csa_pkg::ST_ROOT_INIT;
          end
        end
      end
      csa_pkg::ST_MUL_DEN:  state_next = csa_pkg::ST_MUL_A2;
      csa_pkg::ST_MUL_A2:   state_next = csa_pkg::ST_MUL_AM;
      csa_pkg::ST_MUL_AM:   state_next = csa_pkg::ST_DIV_INIT;
      csa_pkg::ST_DIV_INIT: state_next = csa_pkg::ST_DIV;
      csa_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = csa_pkg::ST_MUL_T;
        end
      end
      csa_pkg::ST_MUL_T:    state_next = csa_pkg::ST_ACC;
      csa_pkg::ST_ACC: begin
        state_next = last ? csa_pkg::ST_ROOT_INIT : csa_pkg::ST_IDLE;
      end
      csa_pkg::ST_ROOT_INIT: state_next = csa_pkg::ST_ROOT;
      csa_pkg::ST_ROOT: begin
        if (root_done) begin
          state_next = csa_pkg::ST_OUT;
        end
      end
      csa_pkg::ST_OUT: begin
        // Wait until the output register is free.
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = csa_pkg::ST_IDLE;
        end
      end
      default: state_next = csa_pkg::ST_IDLE;
    endcase
  end

  // Threshold, sums, flags and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= csa_pkg::THRESHOLD_RESET;
      chi_sum       <= '0;
      error_sum     <= '0;
      saturate_flag <= 1'b0;
      zero_flag     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end

      // A point in range with zero error changes no sum.
      if (in_xfer && !in_skip && in_zero) begin
        zero_flag <= 1'b1;
      end

      if (state == csa_pkg::ST_ACC) begin
        chi_sum   <= chi_add[csa_pkg::SUM_W] ? csa_pkg::SUM_MAX : chi_add[csa_pkg::SUM_W-1:0];
        error_sum <= err_add[csa_pkg::ESUM_W] ? csa_pkg::ESUM_MAX
                                              : err_add[csa_pkg::ESUM_W-1:0];
        if (csat || tsat || chi_add[csa_pkg::SUM_W] || err_add[csa_pkg::ESUM_W]) begin
          saturate_flag <= 1'b1;
        end
      end

      // Clear the set once its result is in the output register.
      if (out_load) begin
        chi_sum       <= '0;
        error_sum     <= '0;
        saturate_flag <= 1'b0;
        zero_flag     <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath: operands, products, serial divide and root
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_abs <= in_a_abs;
      m_abs <= in_m_abs;
      oerr  <= in_oerr;
      last  <= s_axis_tlast;
    end

    case (state)
      csa_pkg::ST_MUL_DEN: den <= csa_pkg::DEN_W'(mul_p);
      csa_pkg::ST_MUL_A2:  a2  <= mul_p;
      csa_pkg::ST_MUL_AM:  am  <= mul_p[2*csa_pkg::VAL_W-2:0];
      csa_pkg::ST_DIV_INIT: begin
        // Quotient overflows when the top dividend bits already reach the divisor.
        crem <= c_rem0;
        csat <= (c_rem0 >= den);
        cn   <= {a2[csa_pkg::VAL_W-1:0], 16'b0};
        trem <= t_rem0;
        tsat <= (t_rem0 >= den);
        tn   <= {am[14:0], 17'b0};
        cnt  <= '0;
      end
      csa_pkg::ST_DIV: begin
        crem <= c_ge ? c_dif[csa_pkg::DEN_W-1:0] : c_sh[csa_pkg::DEN_W-1:0];
        cn   <= {cn[csa_pkg::CHI_Q_W-2:0], c_ge};
        // The error-term quotient is only 32 bits: hold it after its last step.
        if (cnt < csa_pkg::CNT_W'(csa_pkg::T_Q_W)) begin
          trem <= t_ge ? t_dif[csa_pkg::DEN_W-1:0] : t_sh[csa_pkg::DEN_W-1:0];
          tn   <= {tn[csa_pkg::T_Q_W-2:0], t_ge};
        end
        cnt <= cnt + 1'b1;
      end
      csa_pkg::ST_MUL_T: begin
        eterm <= tsat ? csa_pkg::ESUM_MAX : mul_p;
      end
      csa_pkg::ST_ROOT_INIT: begin
        sx   <= error_sum;
        srem <= '0;
        root <= '0;
        cnt  <= '0;
      end
      csa_pkg::ST_ROOT: begin
        sx   <= {sx[csa_pkg::ESUM_W-3:0], 2'b00};
        srem <= s_ge ? s_dif[csa_pkg::ROOT_W:0] : s_sh[csa_pkg::ROOT_W:0];
        root <= {root[csa_pkg::ROOT_W-2:0], s_ge};
        cnt  <= cnt + 1'b1;
      end
      default: begin
      end
    endcase

    if (out_load) begin
      m_axis_tdata <= {csa_pkg::SUM_W'(root), chi_sum};
      m_axis_tuser <= {zero_flag, saturate_flag};
    end
  end

endmodule
